// ===== rtl/usds_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// usds_pkg: shared definitions for the uniform sphere direction sampler
// Widths, constants, cell side-band types and the CORDIC angle table.
// ----------------------------------------------------------------------------
package usds_pkg;

    localparam int FRACTION_BITS_DEF   = 16;
    localparam int ROTATION_STAGES_DEF = 16;

    localparam int IN_W  = 16;
    localparam int OUT_W = 16;

    // Square root of 4*(2^30 - z*z): 34-bit radicand, 17 root bits
    localparam int SQRT_STEPS = 17;
    localparam int RAD_W      = 2 * SQRT_STEPS;
    localparam int ROOT_W     = SQRT_STEPS;
    localparam int REM_W      = SQRT_STEPS + 3;

    localparam int RADIUS_W = 15;
    localparam int ANGLE_W  = 32;
    localparam int GAIN_W   = 32;
    localparam int PROD_W   = RADIUS_W + GAIN_W;

    // Inverse of the infinite-stage CORDIC gain, Q0.32
    localparam logic [GAIN_W-1:0] INV_GAIN_Q32 = 32'h9B74EDA8;

    localparam int SAT_MAG = 32767;

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_1,
        QUAD_2,
        QUAD_3
    } quad_t;

    typedef struct packed {
        logic signed [IN_W-1:0] z;
        logic [IN_W-1:0]        angle;
    } sq_side_t;

    typedef struct packed {
        logic signed [IN_W-1:0] z;
        quad_t                  quad;
    } rot_side_t;

    // atan(2^-idx) in 2^32-per-turn units
    function automatic logic [ANGLE_W-1:0] stage_angle(input int idx);
        logic [ANGLE_W-1:0] a;
        case (idx)
            0:       a = 32'd536870912;
            1:       a = 32'd316933406;
            2:       a = 32'd167458907;
            3:       a = 32'd85004756;
            4:       a = 32'd42667331;
            5:       a = 32'd21354465;
            6:       a = 32'd10679838;
            7:       a = 32'd5340245;
            8:       a = 32'd2670163;
            9:       a = 32'd1335087;
            10:      a = 32'd667544;
            11:      a = 32'd333772;
            12:      a = 32'd166886;
            13:      a = 32'd83443;
            14:      a = 32'd41722;
            15:      a = 32'd20861;
            16:      a = 32'd10430;
            17:      a = 32'd5215;
            18:      a = 32'd2608;
            19:      a = 32'd1304;
            20:      a = 32'd652;
            21:      a = 32'd326;
            22:      a = 32'd163;
            23:      a = 32'd81;
            24:      a = 32'd41;
            25:      a = 32'd20;
            26:      a = 32'd10;
            27:      a = 32'd5;
            28:      a = 32'd3;
            29:      a = 32'd1;
            30:      a = 32'd1;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/usds_sqrt_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// usds_sqrt_cell: one digit step of a pipelined integer square root
// Consume the top two radicand bits, decide one root bit, register the result.
// ----------------------------------------------------------------------------
module usds_sqrt_cell (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 advance,
    input  wire                                 in_valid,
    input  wire [usds_pkg::RAD_W-1:0]           in_rad,
    input  wire [usds_pkg::REM_W-1:0]           in_rem,
    input  wire [usds_pkg::ROOT_W-1:0]          in_root,
    input  wire usds_pkg::sq_side_t             in_side,
    output logic                                out_valid,
    output logic [usds_pkg::RAD_W-1:0]          out_rad,
    output logic [usds_pkg::REM_W-1:0]          out_rem,
    output logic [usds_pkg::ROOT_W-1:0]         out_root,
    output usds_pkg::sq_side_t                  out_side
);

    logic                           valid_reg;
    logic [usds_pkg::RAD_W-1:0]     rad_reg, rad_next;
    logic [usds_pkg::REM_W-1:0]     rem_reg, rem_next;
    logic [usds_pkg::ROOT_W-1:0]    root_reg, root_next;
    usds_pkg::sq_side_t             side_reg;
    logic [usds_pkg::REM_W-1:0]     rem_sh;
    logic [usds_pkg::REM_W-1:0]     trial;
    logic                           fit;

    always_comb
    begin
        rem_sh    = {in_rem[usds_pkg::REM_W-3:0], in_rad[usds_pkg::RAD_W-1 -: 2]};
        trial     = usds_pkg::REM_W'({in_root, 2'b01});
        fit       = (rem_sh >= trial);
        rem_next  = fit ? (rem_sh - trial) : rem_sh;
        root_next = {in_root[usds_pkg::ROOT_W-2:0], fit};
        rad_next  = {in_rad[usds_pkg::RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rad   = rad_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_side  = side_reg;

endmodule
`default_nettype wire

// ===== rtl/usds_cordic_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// usds_cordic_cell: one rotation-mode CORDIC micro-rotation
// Rotate toward the residual angle by atan(2^-STAGE) and register the vector.
// ----------------------------------------------------------------------------
module usds_cordic_cell #(
    parameter int W     = usds_pkg::FRACTION_BITS_DEF + 3,
    parameter int STAGE = 0
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 advance,
    input  wire                                 in_valid,
    input  wire signed [W-1:0]                  in_x,
    input  wire signed [W-1:0]                  in_y,
    input  wire signed [usds_pkg::ANGLE_W-1:0]  in_resid,
    input  wire usds_pkg::rot_side_t            in_side,
    output logic                                out_valid,
    output logic signed [W-1:0]                 out_x,
    output logic signed [W-1:0]                 out_y,
    output logic signed [usds_pkg::ANGLE_W-1:0] out_resid,
    output usds_pkg::rot_side_t                 out_side
);

    localparam logic signed [usds_pkg::ANGLE_W-1:0] STEP_ANGLE =
        usds_pkg::stage_angle(STAGE);

    logic                                   valid_reg;
    logic signed [W-1:0]                    x_reg, x_next;
    logic signed [W-1:0]                    y_reg, y_next;
    logic signed [usds_pkg::ANGLE_W-1:0]    resid_reg, resid_next;
    usds_pkg::rot_side_t                    side_reg;
    logic signed [W-1:0]                    xs;
    logic signed [W-1:0]                    ys;

    always_comb
    begin
        xs = in_x >>> STAGE;
        ys = in_y >>> STAGE;
        if (!in_resid[usds_pkg::ANGLE_W-1])
        begin
            x_next     = in_x - ys;
            y_next     = in_y + xs;
            resid_next = in_resid - STEP_ANGLE;
        end
        else
        begin
            x_next     = in_x + ys;
            y_next     = in_y - xs;
            resid_next = in_resid + STEP_ANGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            resid_reg <= resid_next;
            side_reg  <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_resid = resid_reg;
    assign out_side  = side_reg;

endmodule
`default_nettype wire

// ===== rtl/uniform_sphere_direction_sampler.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// uniform_sphere_direction_sampler: uniform unit direction on the sphere
// Two Q0.16 uniform fractions in, one signed Q1.15 (x, y, z) direction out.
// ----------------------------------------------------------------------------
// Takes one request per cycle while the row advances and returns one
// direction per request, in order. The datapath is two rows of cells: a
// 17-cell square-root row that forms the ring radius s = sqrt(1 - z^2) one
// root bit per cell, and a row of ROTATION_STAGES CORDIC cells that turns s
// into s*cos and s*sin, one micro-rotation per cell. Around them sit one
// stage that squares z, one that rounds the radius and splits the angle into
// quadrant and residual, one that scales the radius by the inverse CORDIC
// gain, and the output register. z is height_fraction - 32768 exactly; x and
// y are rounded to Q1.15 and their magnitudes saturate at 32767. The whole
// row stalls only when a finished direction waits at the output and another
// one is ready behind it, so new requests keep flowing into bubbles while
// m_axis_tready is low. No state is kept between requests.
// ----------------------------------------------------------------------------
module uniform_sphere_direction_sampler #(
    parameter int FRACTION_BITS   = usds_pkg::FRACTION_BITS_DEF,
    parameter int ROTATION_STAGES = usds_pkg::ROTATION_STAGES_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // [15:0] height_fraction, [31:16] angle_fraction
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [47:0] m_axis_tdata    // [15:0] dir_x, [31:16] dir_y, [47:32] dir_z
);

    // Datapath width: FRACTION_BITS plus sign and headroom for the CORDIC gain
    localparam int W    = FRACTION_BITS + 3;
    localparam int WO   = W + 16;
    localparam int SH   = usds_pkg::PROD_W - FRACTION_BITS;
    localparam int X0W  = usds_pkg::PROD_W + 1 - SH;
    localparam int RSH  = (FRACTION_BITS > 15) ? FRACTION_BITS - 15 : 0;
    localparam int LSH  = (FRACTION_BITS < 15) ? 15 - FRACTION_BITS : 0;
    localparam int RND  = (FRACTION_BITS > 15) ? (1 << (FRACTION_BITS - 16)) : 0;
    localparam int ZSQ_W = 2 * usds_pkg::IN_W - 1;

    localparam logic signed [WO-1:0] SAT_POS = WO'(usds_pkg::SAT_MAG);
    localparam logic signed [WO-1:0] SAT_NEG = -WO'(usds_pkg::SAT_MAG);
    localparam logic signed [WO-1:0] RND_W   = WO'(RND);
    localparam logic [ZSQ_W-1:0]     ONE_Q30 = ZSQ_W'(1) << 30;

    // ---- flow control ------------------------------------------------------
    logic advance;
    logic out_load;
    logic last_valid;

    // Load the output register when it is empty or being drained; hold the
    // whole row only if the last cell carries a result that cannot move.
    assign out_load      = !m_axis_tvalid || m_axis_tready;
    assign advance       = !last_valid || out_load;
    assign s_axis_tready = advance;

    // ---- input stage: z and z^2 --------------------------------------------
    logic signed [usds_pkg::IN_W-1:0]   z_in;
    logic signed [2*usds_pkg::IN_W-1:0] z_sq_full;
    logic                               in_valid_reg;
    logic [ZSQ_W-1:0]                   zsq_reg, zsq_next;
    usds_pkg::sq_side_t                 in_side_reg, in_side_next;

    always_comb
    begin
        // height_fraction - 32768 is the height with its top bit flipped
        z_in               = $signed({~s_axis_tdata[15], s_axis_tdata[14:0]});
        z_sq_full          = (2 * usds_pkg::IN_W)'(z_in) * (2 * usds_pkg::IN_W)'(z_in);
        zsq_next           = z_sq_full[ZSQ_W-1:0];
        in_side_next.z     = z_in;
        in_side_next.angle = s_axis_tdata[31:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            zsq_reg     <= zsq_next;
            in_side_reg <= in_side_next;
        end
    end

    // ---- square-root row: isqrt(4 * (2^30 - z^2)) --------------------------
    logic                            sq_valid [0:usds_pkg::SQRT_STEPS];
    logic [usds_pkg::RAD_W-1:0]      sq_rad   [0:usds_pkg::SQRT_STEPS];
    logic [usds_pkg::REM_W-1:0]      sq_rem   [0:usds_pkg::SQRT_STEPS];
    logic [usds_pkg::ROOT_W-1:0]     sq_root  [0:usds_pkg::SQRT_STEPS];
    usds_pkg::sq_side_t              sq_side  [0:usds_pkg::SQRT_STEPS];

    always_comb
    begin
        sq_valid[0] = in_valid_reg;
        sq_rad[0]   = {1'b0, ONE_Q30 - zsq_reg, 2'b00};
        sq_rem[0]   = '0;
        sq_root[0]  = '0;
        sq_side[0]  = in_side_reg;
    end

    for (genvar k = 0; k < usds_pkg::SQRT_STEPS; k++)
    begin : g_sqrt
        usds_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (sq_valid[k]),
            .in_rad    (sq_rad[k]),
            .in_rem    (sq_rem[k]),
            .in_root   (sq_root[k]),
            .in_side   (sq_side[k]),
            .out_valid (sq_valid[k+1]),
            .out_rad   (sq_rad[k+1]),
            .out_rem   (sq_rem[k+1]),
            .out_root  (sq_root[k+1]),
            .out_side  (sq_side[k+1])
        );
    end

    // ---- radius rounding and angle reduction -------------------------------
    logic [usds_pkg::ROOT_W:0]              half_sum;
    logic [usds_pkg::ROOT_W-1:0]            s_wide;
    logic [usds_pkg::IN_W-1:0]              ang_bias;
    logic [usds_pkg::IN_W-1:0]              ang_resid;
    logic                                   rad_valid_reg;
    logic [usds_pkg::RADIUS_W-1:0]          radius_reg, radius_next;
    logic signed [usds_pkg::ANGLE_W-1:0]    rad_resid_reg, rad_resid_next;
    usds_pkg::rot_side_t                    rad_side_reg, rad_side_next;

    always_comb
    begin
        // Round the doubled root to nearest, then clamp to 32767
        half_sum = {1'b0, sq_root[usds_pkg::SQRT_STEPS]} + 1'b1;
        s_wide   = half_sum[usds_pkg::ROOT_W:1];
        if (s_wide > usds_pkg::ROOT_W'(usds_pkg::SAT_MAG))
        begin
            radius_next = usds_pkg::RADIUS_W'(usds_pkg::SAT_MAG);
        end
        else
        begin
            radius_next = s_wide[usds_pkg::RADIUS_W-1:0];
        end

        // Nearest quadrant, residual within plus or minus an eighth of a turn
        ang_bias            = sq_side[usds_pkg::SQRT_STEPS].angle + 16'h2000;
        rad_side_next.quad  = usds_pkg::quad_t'(ang_bias[15:14]);
        rad_side_next.z     = sq_side[usds_pkg::SQRT_STEPS].z;
        ang_resid           = sq_side[usds_pkg::SQRT_STEPS].angle
                              - {ang_bias[15:14], 14'd0};
        rad_resid_next      = $signed({ang_resid, 16'd0});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rad_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rad_valid_reg <= sq_valid[usds_pkg::SQRT_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            radius_reg    <= radius_next;
            rad_resid_reg <= rad_resid_next;
            rad_side_reg  <= rad_side_next;
        end
    end

    // ---- gain pre-scale: s * (1/K) -----------------------------------------
    logic                                   mul_valid_reg;
    logic [usds_pkg::PROD_W-1:0]            prod_reg, prod_next;
    logic signed [usds_pkg::ANGLE_W-1:0]    mul_resid_reg;
    usds_pkg::rot_side_t                    mul_side_reg;

    assign prod_next = usds_pkg::PROD_W'(radius_reg) * usds_pkg::PROD_W'(usds_pkg::INV_GAIN_Q32);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            mul_valid_reg <= rad_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg      <= prod_next;
            mul_resid_reg <= rad_resid_reg;
            mul_side_reg  <= rad_side_reg;
        end
    end

    // ---- CORDIC row --------------------------------------------------------
    logic [usds_pkg::PROD_W:0]              prod_rnd;
    logic                                   rot_valid [0:ROTATION_STAGES];
    logic signed [W-1:0]                    rot_x     [0:ROTATION_STAGES];
    logic signed [W-1:0]                    rot_y     [0:ROTATION_STAGES];
    logic signed [usds_pkg::ANGLE_W-1:0]    rot_resid [0:ROTATION_STAGES];
    usds_pkg::rot_side_t                    rot_side  [0:ROTATION_STAGES];

    always_comb
    begin
        // Round the scaled radius into the datapath's fraction bits
        prod_rnd     = {1'b0, prod_reg} + ((usds_pkg::PROD_W + 1)'(1) << (SH - 1));
        rot_valid[0] = mul_valid_reg;
        rot_x[0]     = $signed({2'b00, prod_rnd[usds_pkg::PROD_W -: X0W]});
        rot_y[0]     = '0;
        rot_resid[0] = mul_resid_reg;
        rot_side[0]  = mul_side_reg;
    end

    for (genvar i = 0; i < ROTATION_STAGES; i++)
    begin : g_cordic
        usds_cordic_cell #(
            .W     (W),
            .STAGE (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (rot_valid[i]),
            .in_x      (rot_x[i]),
            .in_y      (rot_y[i]),
            .in_resid  (rot_resid[i]),
            .in_side   (rot_side[i]),
            .out_valid (rot_valid[i+1]),
            .out_x     (rot_x[i+1]),
            .out_y     (rot_y[i+1]),
            .out_resid (rot_resid[i+1]),
            .out_side  (rot_side[i+1])
        );
    end

    assign last_valid = rot_valid[ROTATION_STAGES];

    // ---- quadrant fix-up, Q1.15 rounding, output register ------------------
    function automatic logic [usds_pkg::OUT_W-1:0] to_q15(input logic signed [W-1:0] v);
        logic signed [WO-1:0] e;
        logic signed [WO-1:0] r;
        e = {{(WO - W){v[W-1]}}, v};
        if (FRACTION_BITS >= 15)
        begin
            r = (e + RND_W) >>> RSH;
        end
        else
        begin
            r = e <<< LSH;
        end
        if (r > SAT_POS)
        begin
            r = SAT_POS;
        end
        else if (r < SAT_NEG)
        begin
            r = SAT_NEG;
        end
        return r[usds_pkg::OUT_W-1:0];
    endfunction

    logic signed [W-1:0]           fx;
    logic signed [W-1:0]           fy;
    logic [47:0]                   out_data_reg, out_data_next;
    logic                          out_valid_reg, out_valid_next;

    always_comb
    begin
        case (rot_side[ROTATION_STAGES].quad)
            usds_pkg::QUAD_1:
            begin
                fx = -rot_y[ROTATION_STAGES];
                fy = rot_x[ROTATION_STAGES];
            end
            usds_pkg::QUAD_2:
            begin
                fx = -rot_x[ROTATION_STAGES];
                fy = -rot_y[ROTATION_STAGES];
            end
            usds_pkg::QUAD_3:
            begin
                fx = rot_y[ROTATION_STAGES];
                fy = -rot_x[ROTATION_STAGES];
            end
            default:
            begin
                fx = rot_x[ROTATION_STAGES];
                fy = rot_y[ROTATION_STAGES];
            end
        endcase
        out_data_next = {rot_side[ROTATION_STAGES].z, to_q15(fy), to_q15(fx)};
    end

    // Hold a waiting result; otherwise take whatever the last cell offers
    assign out_valid_next = out_load ? last_valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
`default_nettype wire

// ===== verif/tb_uniform_sphere_direction_sampler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uniform_sphere_direction_sampler: self-checking bench for the sampler
// Drives (height, angle) fraction pairs into the stream input with random
// gaps and output stalls. A scoreboard predicts each direction with its own
// integer square root and CORDIC, then checks dir_x, dir_y and dir_z in order.
// ----------------------------------------------------------------------------
module tb_uniform_sphere_direction_sampler;

    // CORDIC micro-rotation angles, atan(2^-i) with 2^32 units per full turn
    localparam int     CORDIC_STEPS = 16;
    localparam longint ATAN_STEP [0:CORDIC_STEPS-1] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861
    };

    // Directed requests: poles, equator, quadrant boundaries, extremes
    localparam int DIRECTED_COUNT = 20;
    localparam logic [15:0] DIR_HEIGHT [0:DIRECTED_COUNT-1] = '{
        16'd0, 16'd65535, 16'd32768, 16'd32768, 16'd32768, 16'd32768, 16'd32768,
        16'd32767, 16'd32769, 16'd1, 16'd16384, 16'd49152, 16'd40000, 16'd20000,
        16'd65535, 16'd0, 16'd12345, 16'd54321, 16'd32768, 16'd65534
    };
    localparam logic [15:0] DIR_ANGLE [0:DIRECTED_COUNT-1] = '{
        16'd0, 16'd0, 16'd0, 16'd16384, 16'd32768, 16'd49152, 16'd65535,
        16'd8192, 16'd8191, 16'd24576, 16'd24575, 16'd40960, 16'd57344, 16'd57343,
        16'd65535, 16'd65535, 16'd1, 16'd4096, 16'd8192, 16'd12288
    };

    localparam int RANDOM_PER_PHASE = 600;
    localparam int DRAIN_CYCLES     = 60;

    typedef struct {
        logic signed [usds_pkg::OUT_W-1:0] dir_x;
        logic signed [usds_pkg::OUT_W-1:0] dir_y;
        logic signed [usds_pkg::OUT_W-1:0] dir_z;
    } sphere_dir_t;

    // ------------------------------------------------------------------------
    // Scoreboard: holds the directions still owed by the block, oldest first
    // ------------------------------------------------------------------------
    class direction_scoreboard;
        sphere_dir_t pending_dirs[$];
        int          failures;

        // Bit-by-bit integer square root, floor
        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned root;
            longint unsigned bit_pos;
            root    = 0;
            bit_pos = 64'd1 << 62;
            while (bit_pos > v)
                bit_pos >>= 2;
            while (bit_pos != 0)
            begin
                if (v >= root + bit_pos)
                begin
                    v    = v - (root + bit_pos);
                    root = (root >> 1) + bit_pos;
                end
                else
                    root = root >> 1;
                bit_pos >>= 2;
            end
            return root;
        endfunction

        // Round half up from 16 fraction bits to Q1.15, saturate magnitude
        function logic signed [usds_pkg::OUT_W-1:0] q15_sat(longint v);
            longint r;
            r = (v + 1) >>> 1;
            if (r > usds_pkg::SAT_MAG)
                r = usds_pkg::SAT_MAG;
            if (r < -usds_pkg::SAT_MAG)
                r = -usds_pkg::SAT_MAG;
            return r[usds_pkg::OUT_W-1:0];
        endfunction

        function sphere_dir_t sphere_direction(logic [15:0] height, logic [15:0] angle);
            sphere_dir_t     dir;
            longint          z;
            longint unsigned radicand;
            longint unsigned radius;
            longint unsigned scaled;
            logic [31:0]     turn;
            logic [31:0]     shifted;
            logic [31:0]     resid_bits;
            usds_pkg::quad_t quad;
            longint          resid;
            longint          x;
            longint          y;
            longint          xs;
            longint          ys;
            longint          t;

            z        = longint'(height) - 32768;
            radicand = (64'd1 << 30) - longint'(z * z);
            radius   = (int_sqrt(radicand * 4) + 1) >> 1;
            if (radius > usds_pkg::SAT_MAG)
                radius = usds_pkg::SAT_MAG;

            // Split the binary angle into a quadrant and a residual in [-1/8, 1/8) turn
            turn       = {angle, 16'h0000};
            shifted    = turn + 32'h2000_0000;
            quad       = usds_pkg::quad_t'(shifted[31:30]);
            resid_bits = turn - {shifted[31:30], 30'd0};
            resid      = longint'($signed(resid_bits));

            // Prescale by the inverse gain so the rotation ends at unit scale
            scaled = radius * 64'h9B74_EDA8;
            x      = longint'((scaled + (64'd1 << 30)) >> 31);
            y      = 0;

            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (resid >= 0)
                begin
                    x     = x - ys;
                    y     = y + xs;
                    resid = resid - ATAN_STEP[i];
                end
                else
                begin
                    x     = x + ys;
                    y     = y - xs;
                    resid = resid + ATAN_STEP[i];
                end
            end

            case (quad)
                usds_pkg::QUAD_1:
                begin
                    t = x;
                    x = -y;
                    y = t;
                end
                usds_pkg::QUAD_2:
                begin
                    x = -x;
                    y = -y;
                end
                usds_pkg::QUAD_3:
                begin
                    t = x;
                    x = y;
                    y = -t;
                end
                default: ;
            endcase

            dir.dir_x = q15_sat(x);
            dir.dir_y = q15_sat(y);
            dir.dir_z = z[usds_pkg::OUT_W-1:0];
            return dir;
        endfunction

        function void note_request(logic [15:0] height, logic [15:0] angle);
            pending_dirs.push_back(sphere_direction(height, angle));
        endfunction

        function void check_result(logic [47:0] data);
            sphere_dir_t want;
            if (pending_dirs.size() == 0)
            begin
                $error("direction %h arrived with none expected", data);
                failures++;
                return;
            end
            want = pending_dirs.pop_front();
            if (data[15:0] !== want.dir_x)
            begin
                $error("dir_x mismatch: expected %0d, got %0d", want.dir_x,
                       $signed(data[15:0]));
                failures++;
            end
            if (data[31:16] !== want.dir_y)
            begin
                $error("dir_y mismatch: expected %0d, got %0d", want.dir_y,
                       $signed(data[31:16]));
                failures++;
            end
            if (data[47:32] !== want.dir_z)
            begin
                $error("dir_z mismatch: expected %0d, got %0d", want.dir_z,
                       $signed(data[47:32]));
                failures++;
            end
        endfunction

        function int outstanding();
            return pending_dirs.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block hookup; every input holds a known value from time zero
    // ------------------------------------------------------------------------
    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // [15:0] height_fraction, [31:16] angle_fraction
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;         // [15:0] dir_x, [31:16] dir_y, [47:32] dir_z

    // When set, neither side idles: back-to-back requests and results
    bit steady_flow = 1'b0;

    direction_scoreboard sb = new;

    uniform_sphere_direction_sampler dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Idle cycles before the next request or result; over a third of draws are zero
    function automatic int draw_gap();
        if (steady_flow || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 13);
    endfunction

    // Heights lean toward the poles and the equator, where the radius is extreme
    function automatic logic [15:0] draw_height();
        case ($urandom_range(0, 9))
            0:       return 16'($urandom_range(0, 3));
            1:       return 16'(65535 - $urandom_range(0, 3));
            2:       return 16'(32768 + $urandom_range(0, 6) - 3);
            default: return 16'($urandom);
        endcase
    endfunction

    // Angles lean toward multiples of an eighth turn, where quadrants split
    function automatic logic [15:0] draw_angle();
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom_range(0, 7) * 8192 + $urandom_range(0, 4) - 2);
        return 16'($urandom);
    endfunction

    // Present one request after a random gap and hold it until accepted
    task automatic send_request(input logic [15:0] height, input logic [15:0] angle);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {angle, height};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Drop tvalid and hold until the block has returned every direction owed
    task automatic drain_directions();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.outstanding() != 0);
    endtask

    // Sample both handshakes at the edge; a request is noted the cycle it is taken
    always @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            sb.note_request(s_axis_tdata[15:0], s_axis_tdata[31:16]);
        if (m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // Result side: stall a random number of cycles before taking each direction
    initial
    begin
        int gap;
        wait (rst_n);
        forever
        begin
            gap = draw_gap();
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    // Main sequence: reset, directed corners, drain, then three random phases
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_COUNT; i++)
            send_request(DIR_HEIGHT[i], DIR_ANGLE[i]);

        // Hold off the sender until the pipeline is completely empty
        drain_directions();

        // Middle phase runs with no idling on either side to fill the pipeline
        for (int phase = 0; phase < 3; phase++)
        begin
            steady_flow = (phase == 1);
            repeat (RANDOM_PER_PHASE)
                send_request(draw_height(), draw_angle());
        end
        steady_flow = 1'b0;

        drain_directions();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Timeout: far beyond the slowest legal run with every gap and stall at its longest
    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
